@@ rtl/utu_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    localparam logic [1:0] ST_UNIT  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    localparam logic [20:0] LIMIT_SEQ1  = 21'h00007f;
    localparam logic [20:0] LIMIT_SEQ2  = 21'h0007ff;
    localparam logic [20:0] LIMIT_SEQ3  = 21'h00ffff;
    localparam logic [20:0] MAX_CODE    = 21'h10ffff;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [15:0] HIGH_BASE   = 16'hd800;
    localparam logic [15:0] LOW_BASE    = 16'hdc00;

    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] ASCII_END = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        last;
    } result_t;

endpackage

@@ rtl/utu_decode.sv @@
// Decoder state and per-byte conversion logic for the UTF-8 to UTF-16 transcoder.
module utu_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         in_byte,
    input  logic [15:0]        out_capacity,
    output logic [1:0]         res_count,
    output utu_pkg::result_t   res0,
    output utu_pkg::result_t   res1
);

    utu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  seq_length_reg, seq_length_next;
    logic [20:0] acc_reg, acc_next;
    logic [15:0] units_reg, units_next;

    logic [16:0] units_plus1;
    logic        free1;
    logic        free2;
    logic [20:0] acc_shift;
    logic [1:0]  bytes_dec;
    logic [20:0] limit;
    logic [20:0] plane_off;
    logic        fail;
    logic [1:0]  count;

    always_comb
    begin
        units_plus1 = {1'b0, units_reg} + 17'd1;
        free1       = out_capacity > units_reg;
        free2       = {1'b0, out_capacity} > units_plus1;
        acc_shift   = {acc_reg[14:0], in_byte[5:0]};
        bytes_dec   = bytes_left_reg - 2'd1;
        plane_off   = acc_shift - utu_pkg::PLANE1_BASE;
        case (seq_length_reg)
            2'd3:    limit = utu_pkg::LIMIT_SEQ3;
            2'd2:    limit = utu_pkg::LIMIT_SEQ2;
            default: limit = utu_pkg::LIMIT_SEQ1;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        acc_next        = acc_reg;
        units_next      = units_reg;
        fail            = 1'b0;
        count           = 2'd0;
        res0            = '{code_unit: 16'd0, status: utu_pkg::ST_UNIT, last: 1'b1};
        res1            = '{code_unit: 16'd0, status: utu_pkg::ST_UNIT, last: 1'b1};

        unique case (phase_reg)
            utu_pkg::PH_DROP:
            begin
                if (in_byte == 8'd0)
                begin
                    phase_next = utu_pkg::PH_IDLE;
                    units_next = 16'd0;
                end
            end
            utu_pkg::PH_COLLECT:
            begin
                if (in_byte < utu_pkg::ASCII_END)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    acc_next        = acc_shift;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 2'd0)
                    begin
                        if (acc_shift <= limit || acc_shift > utu_pkg::MAX_CODE || !free2)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            phase_next      = utu_pkg::PH_IDLE;
                            seq_length_next = 2'd0;
                            acc_next        = 21'd0;
                            if (acc_shift > utu_pkg::LIMIT_SEQ3)
                            begin
                                res0.code_unit = utu_pkg::HIGH_BASE
                                                 + {6'd0, plane_off[19:10]};
                                res0.last      = 1'b0;
                                res1.code_unit = utu_pkg::LOW_BASE
                                                 + {6'd0, plane_off[9:0]};
                                count          = 2'd2;
                                units_next     = units_reg + 16'd2;
                            end
                            else
                            begin
                                res0.code_unit = acc_shift[15:0];
                                count          = 2'd1;
                                units_next     = units_plus1[15:0];
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = utu_pkg::PH_IDLE;
                if (in_byte < utu_pkg::ASCII_END)
                begin
                    if (!free1)
                    begin
                        fail = 1'b1;
                    end
                    else if (in_byte == 8'd0)
                    begin
                        res0.status = utu_pkg::ST_END;
                        count       = 2'd1;
                        units_next  = 16'd0;
                    end
                    else
                    begin
                        res0.code_unit = {8'd0, in_byte};
                        count          = 2'd1;
                        units_next     = units_plus1[15:0];
                    end
                end
                else if (!free2)
                begin
                    fail = 1'b1;
                end
                else if (in_byte >= utu_pkg::LEAD4_MIN)
                begin
                    acc_next        = {18'd0, in_byte[2:0]};
                    seq_length_next = 2'd3;
                    bytes_left_next = 2'd3;
                    phase_next      = utu_pkg::PH_COLLECT;
                end
                else if (in_byte >= utu_pkg::LEAD3_MIN)
                begin
                    acc_next        = {17'd0, in_byte[3:0]};
                    seq_length_next = 2'd2;
                    bytes_left_next = 2'd2;
                    phase_next      = utu_pkg::PH_COLLECT;
                end
                else if (in_byte >= utu_pkg::LEAD2_MIN)
                begin
                    acc_next        = {16'd0, in_byte[4:0]};
                    seq_length_next = 2'd1;
                    bytes_left_next = 2'd1;
                    phase_next      = utu_pkg::PH_COLLECT;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
        endcase

        if (fail)
        begin
            res0            = '{code_unit: 16'd0, status: utu_pkg::ST_ERROR, last: 1'b1};
            count           = 2'd1;
            bytes_left_next = 2'd0;
            seq_length_next = 2'd0;
            acc_next        = 21'd0;
            if (in_byte == 8'd0)
            begin
                phase_next = utu_pkg::PH_IDLE;
                units_next = 16'd0;
            end
            else
            begin
                phase_next = utu_pkg::PH_DROP;
            end
        end

        res_count = fire ? count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= utu_pkg::PH_IDLE;
            bytes_left_reg <= 2'd0;
            seq_length_reg <= 2'd0;
            acc_reg        <= 21'd0;
            units_reg      <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            acc_reg        <= acc_next;
            units_reg      <= units_next;
        end
    end

endmodule

@@ rtl/utu_out_queue.sv @@
// Two-slot result register feeding the output stream of the transcoder.
module utu_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_count,
    input  utu_pkg::result_t   push0,
    input  utu_pkg::result_t   push1,
    input  logic               pop_ready,
    output logic               room,
    output logic               head_valid,
    output utu_pkg::result_t   head
);

    logic [1:0]       count_reg, count_next;
    utu_pkg::result_t slot0_reg, slot0_next;
    utu_pkg::result_t slot1_reg, slot1_next;
    logic             pop;
    logic [1:0]       remain;

    always_comb
    begin
        pop        = (count_reg != 2'd0) && pop_ready;
        remain     = count_reg - {1'b0, pop};
        room       = remain == 2'd0;
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (push_count != 2'd0)
        begin
            slot0_next = push0;
            slot1_next = push1;
        end
        count_next = remain + push_count;
        head_valid = count_reg != 2'd0;
        head       = slot0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, result queue.
//
//  channel   direction  tdata                  tuser          tlast
//  s_axis    in         [7:0] in_byte          -              -
//  m_axis    out        [15:0] code_unit       [1:0] status   last
//  cfg       in         [15:0] out_capacity    -              -
//
// One byte is taken per cycle while the result queue has room; a byte is held in the
// input register, decoded, and its results are registered in the result queue.
// A byte that decodes to a surrogate pair yields two results, the high unit first.
// Reset returns the decoder to idle, clears the unit count and sets capacity 4096.
// A stalled output holds the queue; the input register then holds its byte.
module utf8_to_utf16_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata       // [15:0] out_capacity
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [15:0]      capacity_reg;
    logic             room;
    logic             fire;
    logic [1:0]       res_count;
    utu_pkg::result_t res0;
    utu_pkg::result_t res1;
    utu_pkg::result_t head;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            capacity_reg <= utu_pkg::CAPACITY_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    utu_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .in_byte      (in_byte_reg),
        .out_capacity (capacity_reg),
        .res_count    (res_count),
        .res0         (res0),
        .res1         (res1)
    );

    utu_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .pop_ready  (m_axis_tready),
        .room       (room),
        .head_valid (m_axis_tvalid),
        .head       (head)
    );

    assign m_axis_tdata = head.code_unit;
    assign m_axis_tuser = head.status;
    assign m_axis_tlast = head.last;

endmodule

@@ verif/utf8_to_utf16_transcoder_tb.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: directed table, then random strings.
module utf8_to_utf16_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 55;
    localparam int NUM_VECS      = 25;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        cap_write;
        logic [15:0] cap;
        logic        fixed;
        logic [15:0] unit;
        logic [1:0]  status;
    } vec_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    utu_pkg::result_t pending_units[$];
    logic [7:0]  str_bytes[$];
    logic [7:0]  carry_bytes[$];
    int          errors;
    int          cycles;
    bit          quiet;
    bit          hold_off;

    // decoder state mirrored for prediction
    utu_pkg::phase_t dec_phase;
    logic [1:0]  cont_left;
    logic [1:0]  cont_total;
    logic [20:0] code_acc;
    logic [15:0] units_used;
    logic [15:0] capacity;

    vec_t vecs [NUM_VECS] = '{
        '{8'h41, 1'b0, 16'd0, 1'b1, 16'h0041, utu_pkg::ST_UNIT},
        '{8'h00, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_END},
        '{8'hc2, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hc0, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hf4, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h8f, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hbf, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hff, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'he0, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h9f, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hbf, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR},
        '{8'h00, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hf4, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h90, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h80, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h80, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR},
        '{8'h00, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hc1, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR},
        '{8'h00, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'hc3, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h00, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR},
        '{8'h41, 1'b1, 16'd2, 1'b1, 16'h0041, utu_pkg::ST_UNIT},
        '{8'hc3, 1'b0, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR},
        '{8'h00, 1'b0, 16'd0, 1'b0, 16'h0000, utu_pkg::ST_UNIT},
        '{8'h00, 1'b1, 16'd0, 1'b1, 16'h0000, utu_pkg::ST_ERROR}
    };

    utf8_to_utf16_transcoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic utu_pkg::result_t abort_string(input logic [7:0] b);
        cont_left  = 2'd0;
        cont_total = 2'd0;
        code_acc   = '0;
        if (b == 8'h00)
        begin
            dec_phase  = utu_pkg::PH_IDLE;
            units_used = '0;
        end
        else
        begin
            dec_phase = utu_pkg::PH_DROP;
        end
        return '{16'h0000, utu_pkg::ST_ERROR, 1'b1};
    endfunction

    task automatic transcode_byte(input logic [7:0] b, output int n,
                                  output utu_pkg::result_t r0, output utu_pkg::result_t r1);
        logic [20:0] v;
        logic [20:0] lim;
        logic [15:0] room;
        logic [20:0] w;
        n    = 0;
        r0   = '0;
        r1   = '0;
        room = (capacity > units_used) ? capacity - units_used : 16'd0;
        case (dec_phase)
            utu_pkg::PH_DROP:
            begin
                if (b == 8'h00)
                begin
                    dec_phase  = utu_pkg::PH_IDLE;
                    units_used = '0;
                end
            end
            utu_pkg::PH_COLLECT:
            begin
                if (b < utu_pkg::ASCII_END)
                begin
                    r0 = abort_string(b);
                    n  = 1;
                end
                else
                begin
                    code_acc  = {code_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                    begin
                        v   = code_acc;
                        lim = (cont_total == 2'd3) ? utu_pkg::LIMIT_SEQ3 :
                              (cont_total == 2'd2) ? utu_pkg::LIMIT_SEQ2 : utu_pkg::LIMIT_SEQ1;
                        n   = 1;
                        if (v <= lim || v > utu_pkg::MAX_CODE || room < 16'd2)
                        begin
                            r0 = abort_string(b);
                        end
                        else
                        begin
                            dec_phase  = utu_pkg::PH_IDLE;
                            cont_total = 2'd0;
                            code_acc   = '0;
                            if (v > utu_pkg::LIMIT_SEQ3)
                            begin
                                w  = v - utu_pkg::PLANE1_BASE;
                                r0 = '{utu_pkg::HIGH_BASE + {6'd0, w[19:10]},
                                       utu_pkg::ST_UNIT, 1'b0};
                                r1 = '{utu_pkg::LOW_BASE + {6'd0, w[9:0]},
                                       utu_pkg::ST_UNIT, 1'b1};
                                units_used = units_used + 16'd2;
                                n  = 2;
                            end
                            else
                            begin
                                r0 = '{v[15:0], utu_pkg::ST_UNIT, 1'b1};
                                units_used = units_used + 16'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                dec_phase = utu_pkg::PH_IDLE;
                if (b < utu_pkg::ASCII_END)
                begin
                    n = 1;
                    if (room < 16'd1)
                        r0 = abort_string(b);
                    else if (b == 8'h00)
                    begin
                        r0 = '{16'h0000, utu_pkg::ST_END, 1'b1};
                        units_used = '0;
                    end
                    else
                    begin
                        r0 = '{{8'h00, b}, utu_pkg::ST_UNIT, 1'b1};
                        units_used = units_used + 16'd1;
                    end
                end
                else if (room < 16'd2 || b < utu_pkg::LEAD2_MIN)
                begin
                    r0 = abort_string(b);
                    n  = 1;
                end
                else
                begin
                    if (b >= utu_pkg::LEAD4_MIN)
                    begin
                        code_acc   = {18'd0, b[2:0]};
                        cont_total = 2'd3;
                    end
                    else if (b >= utu_pkg::LEAD3_MIN)
                    begin
                        code_acc   = {17'd0, b[3:0]};
                        cont_total = 2'd2;
                    end
                    else
                    begin
                        code_acc   = {16'd0, b[4:0]};
                        cont_total = 2'd1;
                    end
                    cont_left = cont_total;
                    dec_phase = utu_pkg::PH_COLLECT;
                end
            end
        endcase
    endtask

    task automatic offer_byte(input logic [7:0] b);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        int               n;
        utu_pkg::result_t r0;
        utu_pkg::result_t r1;
        offer_byte(b);
        transcode_byte(b, n, r0, r1);
        if (n > 0)
            pending_units.push_back(r0);
        if (n > 1)
            pending_units.push_back(r1);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity  = v;
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] x);
        return {($urandom_range(0, 5) == 0) ? 2'b11 : 2'b10, x};
    endfunction

    task automatic put_code(input logic [20:0] cp, input int len);
        case (len)
            1:
                str_bytes.push_back(cp[7:0]);
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
            3:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back(cont_byte(cp[11:6]));
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
            default:
            begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back(cont_byte(cp[17:12]));
                str_bytes.push_back(cont_byte(cp[11:6]));
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
        endcase
    endtask

    task automatic add_noise();
        int len;
        case ($urandom_range(0, 3))
            0:
                str_bytes.push_back(8'($urandom_range(1, 255)));
            1:
            begin
                len = $urandom_range(2, 4);
                put_code(21'($urandom_range(0, (len == 2) ? 32'h7f :
                                                (len == 3) ? 32'h7ff : 32'hffff)), len);
            end
            2:
                put_code(21'($urandom_range(32'h110000, 32'h1fffff)), 4);
            default:
            begin
                str_bytes.push_back(8'($urandom_range(32'hc2, 32'hff)));
                if ($urandom_range(0, 1) == 1)
                    str_bytes.push_back(8'($urandom_range(1, 127)));
            end
        endcase
    endtask

    task automatic build_string();
        int nchars;
        int k;
        str_bytes.delete();
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        repeat (nchars)
        begin
            k = $urandom_range(0, 19);
            if (k < 2)
                add_noise();
            else if (k < 9)
                put_code(21'($urandom_range(1, 32'h7f)), 1);
            else if (k < 12)
                put_code(21'($urandom_range(32'h80, 32'h7ff)), 2);
            else if (k < 14)
                put_code(21'($urandom_range(32'h800, 32'hffff)), 3);
            else if (k < 15)
                put_code(21'($urandom_range(32'hd800, 32'hdfff)), 3);
            else
                put_code(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
        end
        str_bytes.push_back(8'h00);
    endtask

    function automatic logic [15:0] phase_capacity(input int ph);
        case (ph)
            0:       return utu_pkg::CAPACITY_RESET;
            1:       return 16'hffff;
            2:       return 16'd1;
            3:       return 16'd2;
            4:       return 16'd3;
            5:       return 16'($urandom_range(4, 12));
            6:       return 16'($urandom_range(13, 400));
            default: return 16'hffff;
        endcase
    endfunction

    // drive m_axis_tready: random stalls, one long hold-off on request
    initial
    begin : sink
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off      <= 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left     = stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left     = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        utu_pkg::result_t got;
        utu_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (pending_units.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected transaction unit=%h status=%0d last=%0b",
                             $time, got.code_unit, got.status, got.last);
            end
            else
            begin
                want = pending_units.pop_front();
                if (got !== want)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display(
                            "%0t: expected unit=%h st=%0d last=%0b, got unit=%h st=%0d last=%0b",
                            $time, want.code_unit, want.status, want.last,
                            got.code_unit, got.status, got.last);
                end
            end
        end
    end

    initial
    begin : stimulus
        int               n;
        int               cut;
        int               wait_cycles;
        utu_pkg::result_t r0;
        utu_pkg::result_t r1;
        errors        = 0;
        quiet         = 1'b0;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'h0000;
        dec_phase     = utu_pkg::PH_IDLE;
        cont_left     = 2'd0;
        cont_total    = 2'd0;
        code_acc      = '0;
        units_used    = '0;
        capacity      = utu_pkg::CAPACITY_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vecs[i])
        begin
            if (vecs[i].cap_write)
                set_capacity(vecs[i].cap);
            offer_byte(vecs[i].in_byte);
            transcode_byte(vecs[i].in_byte, n, r0, r1);
            if (vecs[i].fixed)
                pending_units.push_back('{vecs[i].unit, vecs[i].status, 1'b1});
            else
            begin
                if (n > 0)
                    pending_units.push_back(r0);
                if (n > 1)
                    pending_units.push_back(r1);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_capacity(phase_capacity(ph));
            quiet = (ph == 0);
            if (ph == 0)
                hold_off <= 1'b1;
            while (carry_bytes.size() > 0)
                feed_byte(carry_bytes.pop_front());
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                build_string();
                foreach (str_bytes[i])
                    feed_byte(str_bytes[i]);
                n = n + str_bytes.size();
            end
            // at random, leave a string unfinished across the next register write
            if ($urandom_range(0, 1) == 1)
            begin
                build_string();
                cut = (str_bytes.size() > 1) ? $urandom_range(1, str_bytes.size() - 1) : 1;
                for (int i = 0; i < str_bytes.size(); i++)
                begin
                    if (i < cut)
                        feed_byte(str_bytes[i]);
                    else
                        carry_bytes.push_back(str_bytes[i]);
                end
            end
        end
        quiet = 1'b0;
        while (carry_bytes.size() > 0)
            feed_byte(carry_bytes.pop_front());

        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_units.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles = wait_cycles + 1;
        end
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (pending_units.size() != 0)
        begin
            errors = errors + 1;
            $display("%0t: %0d expected transactions never arrived", $time,
                     pending_units.size());
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ utf8_to_utf16_transcoder.f @@
rtl/utu_pkg.sv
rtl/utu_decode.sv
rtl/utu_out_queue.sv
rtl/utf8_to_utf16_transcoder.sv
verif/utf8_to_utf16_transcoder_tb.sv
